/* src/clws_pkg.sv */
// Package for the character LCD write sequencer.
// Holds item codes, register indexes, reset values and the shared types.
// No dependencies.
package clws_pkg;

  // Codes of the mode field of an input item.
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_CMD  = 2'd1;
  localparam logic [1:0] MODE_DATA = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 2'd2;

  localparam int unsigned CFG_DATA_W = 16;

  // Configuration reset values.
  localparam logic                  FOUR_BIT_RESET = 1'b1;
  localparam logic [CFG_DATA_W-1:0] PULSE_RESET    = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] SETTLE_RESET   = 16'd10000;

  localparam logic [7:0] HIGH_NIBBLE = 8'hF0;
  localparam logic [7:0] LOW_NIBBLE  = 8'h0F;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Classified item as it travels through the queue.
  typedef enum logic [1:0] {
    OP_TICK,
    OP_CMD,
    OP_DATA,
    OP_NOP
  } clws_op_e;

  typedef struct packed {
    clws_op_e   op;
    logic [7:0] value;
  } clws_cmd_t;

  // Transfer phases, one-hot.
  typedef enum logic [4:0] {
    PH_IDLE         = 5'b00001,
    PH_PULSE_LAST   = 5'b00010,
    PH_SETTLE_LAST  = 5'b00100,
    PH_PULSE_FIRST  = 5'b01000,
    PH_SETTLE_FIRST = 5'b10000
  } clws_phase_e;

  // Configuration as seen by the back end.
  typedef struct packed {
    logic                  four_bit_bus;
    logic [CFG_DATA_W-1:0] pulse_ticks;
    logic [CFG_DATA_W-1:0] settle_ticks;
  } clws_cfg_t;

endpackage

/* src/clws_if.sv */
// Channel interfaces of the character LCD write sequencer.
// Depends on clws_pkg for the configuration field widths.
interface clws_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

interface clws_out_if;
  logic       valid;
  logic       ready;
  logic       register_select;
  logic       enable_level;
  logic [7:0] data_bus;
  logic       busy_res;
  logic       accepted;

  modport source (output valid, register_select, enable_level, data_bus, busy_res, accepted,
                  input ready);
  modport sink   (input valid, register_select, enable_level, data_bus, busy_res, accepted,
                  output ready);
endinterface

interface clws_cfg_if;
  import clws_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/character_lcd_write_sequencer.sv */
// Top level of the character LCD write sequencer.
// Depends on clws_pkg, clws_if, clws_front and clws_back.
//
// Usage: items enter on in_i (mode: tick, command byte or character byte;
// value: the byte). Each item yields exactly one result on out_o with the
// RS, enable and data pin levels after the item, a busy flag and whether a
// send was taken. Sends are refused while a transfer runs; tick items pace
// the enable pulse and settle time, in 4-bit mode twice per byte.
// Configuration writes arrive on cfg_i (index 0 bus width, 1 pulse ticks,
// 2 settle ticks), always ready; the user must make them while no item is in flight (the block does not check).
// Throughput is one item per clock while out_o is ready; the front queues
// classified items and the back resolves one per cycle, as out_o allows, into
// a result register that holds each result until out_o takes it.
// If out_o stalls, the two-entry queue fills and in_i.ready drops; nothing is
// lost. Reset sets the phase to idle, clears out_o.valid and the internal bus
// byte, and sets 4-bit mode, 1000 pulse ticks and 10000 settle ticks.
module character_lcd_write_sequencer #(
  parameter int unsigned TICK_COUNTER_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  clws_in_if.sink    in_i,
  clws_cfg_if.sink   cfg_i,
  clws_out_if.source out_o
);
  import clws_pkg::*;

  clws_cfg_t cfg_q;
  logic      cmd_valid, cmd_ready;
  clws_cmd_t cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.four_bit_bus <= FOUR_BIT_RESET;
      cfg_q.pulse_ticks  <= PULSE_RESET;
      cfg_q.settle_ticks <= SETTLE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_FOUR_BIT: cfg_q.four_bit_bus <= cfg_i.data[0];
        CFG_PULSE:    cfg_q.pulse_ticks  <= cfg_i.data;
        CFG_SETTLE:   cfg_q.settle_ticks <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  clws_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  clws_back #(
    .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_o       (out_o)
  );

endmodule

/* src/clws_front.sv */
// Front end of the LCD write sequencer: classifies input items and queues them.
// Depends on clws_pkg and clws_in_if.
module clws_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  clws_in_if.sink             in_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output clws_pkg::clws_cmd_t cmd_o
);
  import clws_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  clws_cmd_t           mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  clws_cmd_t           cmd_in;
  logic                push, pop;

  always_comb begin
    cmd_in.value = in_i.value;
    case (in_i.mode)
      MODE_TICK: cmd_in.op = OP_TICK;
      MODE_CMD:  cmd_in.op = OP_CMD;
      MODE_DATA: cmd_in.op = OP_DATA;
      default:   cmd_in.op = OP_NOP;
    endcase
  end

  assign in_i.ready  = (count_q != CntW'(QUEUE_DEPTH));
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

/* src/clws_back.sv */
// Back end of the LCD write sequencer: phase machine, tick counter and result register.
// Depends on clws_pkg and clws_out_if.
module clws_back #(
  parameter int unsigned TICK_COUNTER_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clws_pkg::clws_cfg_t cfg_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  clws_pkg::clws_cmd_t cmd_i,
  clws_out_if.source          out_o
);
  import clws_pkg::*;

  localparam int unsigned CntW = TICK_COUNTER_WIDTH;
  localparam int unsigned CmpW = (CntW > CFG_DATA_W) ? CntW : CFG_DATA_W;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  clws_phase_e     phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [7:0]      held_byte_q, held_byte_d;
  logic            held_sel_q, held_sel_d;
  logic [7:0]      bus_q, bus_d;
  logic            out_valid_q;
  logic            res_sel_q, res_en_q, res_busy_q, res_took_q;
  logic [7:0]      res_bus_q;
  logic            took;
  logic            pop, pulse_done, settle_done, at_max;

  assign cmd_ready_o = !out_valid_q || out_o.ready;
  assign pop         = cmd_valid_i && cmd_ready_o;

  // The count saturates; reaching its maximum also ends a phase.
  assign at_max      = (cnt_q == CntMax);
  assign cnt_inc     = at_max ? cnt_q : cnt_q + 1'b1;
  assign pulse_done  = (CmpW'(cnt_inc) >= CmpW'(cfg_i.pulse_ticks)) || (cnt_inc == CntMax);
  assign settle_done = (CmpW'(cnt_inc) >= CmpW'(cfg_i.settle_ticks)) || (cnt_inc == CntMax);

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    held_byte_d = held_byte_q;
    held_sel_d  = held_sel_q;
    bus_d       = bus_q;
    took        = 1'b0;
    case (cmd_i.op)
      OP_TICK: begin
        case (phase_q)
          PH_IDLE: begin
          end
          PH_PULSE_FIRST: begin
            cnt_d = cnt_inc;
            if (pulse_done) begin
              phase_d = PH_SETTLE_FIRST;
              cnt_d   = '0;
            end
          end
          PH_SETTLE_FIRST: begin
            cnt_d = cnt_inc;
            if (settle_done) begin
              bus_d   = 8'((held_byte_q & LOW_NIBBLE) << 4);
              phase_d = PH_PULSE_LAST;
              cnt_d   = '0;
            end
          end
          PH_PULSE_LAST: begin
            cnt_d = cnt_inc;
            if (pulse_done) begin
              phase_d = PH_SETTLE_LAST;
              cnt_d   = '0;
            end
          end
          PH_SETTLE_LAST: begin
            cnt_d = cnt_inc;
            if (settle_done) begin
              phase_d = PH_IDLE;
              cnt_d   = '0;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            cnt_d   = '0;
          end
        endcase
      end
      OP_CMD, OP_DATA: begin
        if (phase_q == PH_IDLE) begin
          held_byte_d = cmd_i.value;
          held_sel_d  = (cmd_i.op == OP_DATA);
          cnt_d       = '0;
          took        = 1'b1;
          if (cfg_i.four_bit_bus) begin
            bus_d   = cmd_i.value & HIGH_NIBBLE;
            phase_d = PH_PULSE_FIRST;
          end else begin
            bus_d   = cmd_i.value;
            phase_d = PH_PULSE_LAST;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      held_byte_q <= '0;
      held_sel_q  <= 1'b0;
      bus_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        phase_q     <= phase_d;
        cnt_q       <= cnt_d;
        held_byte_q <= held_byte_d;
        held_sel_q  <= held_sel_d;
        bus_q       <= bus_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_sel_q  <= held_sel_d;
      res_en_q   <= (phase_d == PH_PULSE_FIRST) || (phase_d == PH_PULSE_LAST);
      res_bus_q  <= bus_d;
      res_busy_q <= (phase_d != PH_IDLE);
      res_took_q <= took;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.register_select = res_sel_q;
  assign out_o.enable_level    = res_en_q;
  assign out_o.data_bus        = res_bus_q;
  assign out_o.busy_res        = res_busy_q;
  assign out_o.accepted        = res_took_q;

endmodule
